### hw/rtl/sjs_pkg.sv
package sjs_pkg;

	localparam int MAX_WINDOW = 32;
	localparam int BASES      = 4;
	localparam int VALUE_BITS = 16;
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 6;
	localparam int SUM_W      = 23;
	localparam int MAG_W      = VALUE_BITS + 1;
	localparam int SCALE_W    = 32;
	localparam int PROD_W     = MAG_W + SCALE_W;
	localparam int AX_W       = 32;
	localparam int DEN_W      = 40;
	localparam int NUM_W      = 41;
	localparam int DVD_W      = 55;
	localparam int DVS_W      = 41;
	localparam int SIM_W      = 16;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int BASE_W     = 2;

	localparam logic OP_MOTIF = 1'b0;
	localparam logic OP_PUSH  = 1'b1;

	localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(MAX_WINDOW);

	typedef logic [BASES-1:0][VALUE_BITS-1:0] row_t;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] row_index;
		logic             start_req;
		row_t             vals;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	// Magnitude of a signed value, one bit wider so that the most negative fits.
	function automatic logic [MAG_W-1:0] mag(input logic [VALUE_BITS-1:0] v);
		logic [MAG_W-1:0] e;
		e = {v[VALUE_BITS-1], v};
		return v[VALUE_BITS-1] ? (~e + 1'b1) : e;
	endfunction

endpackage

### hw/rtl/sjs_if.sv
interface sjs_item_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   op;
	logic [sjs_pkg::IDX_W-1:0]              row_index;
	logic                                   start_req;
	logic signed [sjs_pkg::VALUE_BITS-1:0]  value_a;
	logic signed [sjs_pkg::VALUE_BITS-1:0]  value_c;
	logic signed [sjs_pkg::VALUE_BITS-1:0]  value_g;
	logic signed [sjs_pkg::VALUE_BITS-1:0]  value_t;

	modport source (output valid, op, row_index, start_req, value_a, value_c, value_g,
		value_t, input ready);
	modport sink (input valid, op, row_index, start_req, value_a, value_c, value_g,
		value_t, output ready);
endinterface

interface sjs_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [sjs_pkg::SIM_W-1:0]  similarity;
	logic [sjs_pkg::SUM_W-1:0]         window_abs_sum;
	logic                              zero_denominator;

	modport source (output valid, similarity, window_abs_sum, zero_denominator, input ready);
	modport sink (input valid, similarity, window_abs_sum, zero_denominator, output ready);
endinterface

### hw/rtl/sliding_continuous_jaccard_scan_unit.sv
// Sliding continuous Jaccard scan. Items with op 0 load one motif row (four
// signed Q4.12 base values) at row_index; items with op 1 push one score row into
// a 32-row circular window, and start_req on a push begins a new sequence. Once
// window_rows rows have been pushed since the last start, each push yields one
// item carrying the window's absolute score sum, the Q1.14 similarity and a flag
// for a zero union sum. Input items enter a four-entry queue, so the port keeps
// taking items, as long as the queue is not full, while the back end works and
// while a finished result waits on the output register. A motif load or a push
// that gives no result is retired as the back end pops it from the queue. A
// push that gives a result runs a sum pass, a scale division (skipped when the
// window sum is zero), a comparison pass, which shares one multiplier across
// the four bases, and a final division (skipped when the union sum is zero).
// Both divisions run on one bit-serial divider. The user must write window_rows
// through cfg_wr_en and cfg_wr_data only while the block is idle, which the
// block does not enforce. A value of 0 acts as 1 and a value above 32 acts as 32.
module sliding_continuous_jaccard_scan_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	sjs_item_if.sink                  items,
	sjs_result_if.source              results,
	input  logic                      cfg_wr_en,
	input  logic [sjs_pkg::CNT_W-1:0] cfg_wr_data
);
	import sjs_pkg::*;

	logic [CNT_W-1:0] win_rows_q;
	logic [CNT_W-1:0] w_eff;
	qhead_t           head;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_rows_q <= WIN_RESET;
		end else if (cfg_wr_en) begin
			win_rows_q <= cfg_wr_data;
		end
	end

	// Clamp the window length into the supported range.
	assign w_eff = (win_rows_q == '0) ? CNT_W'(1) :
		(win_rows_q > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : win_rows_q;

	sjs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.pop    (pop),
		.head   (head)
	);

	sjs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.w_eff   (w_eff),
		.results (results)
	);

	// The back end never takes an item from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head.valid)
		else $error("queue popped while empty");

	// A zero union sum always reports a similarity of zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.zero_denominator |-> results.similarity == '0)
		else $error("nonzero similarity with zero denominator");

	// The similarity stays within plus and minus one in Q1.14.
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.similarity <= 16'sd16384)
			&& (results.similarity >= -16'sd16384))
		else $error("similarity out of range");

endmodule

### hw/rtl/sjs_front.sv
module sjs_front (
	input  logic            clk,
	input  logic            arst_n,
	sjs_item_if.sink        items,
	input  logic            pop,
	output sjs_pkg::qhead_t head
);
	import sjs_pkg::*;

	item_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;
	logic               push;
	item_t              in_item;

	assign items.ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign push        = items.valid && items.ready;

	// Classify the item on entry: motif loads and pushes are tagged by op.
	always_comb begin
		in_item.op        = items.op;
		in_item.row_index = items.row_index;
		in_item.start_req = (items.op == OP_PUSH) && items.start_req;
		in_item.vals      = {items.value_t, items.value_g, items.value_c, items.value_a};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = q_mem_q[rd_ptr_q];

endmodule

### hw/rtl/sjs_div.sv
module sjs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sjs_pkg::DVD_W-1:0] dividend,
	input  logic [sjs_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [sjs_pkg::DVD_W-1:0] quotient
);
	import sjs_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   sh;
	logic [DVS_W:0]   dif;
	logic             ge;

	// One quotient bit per cycle, restoring form.
	assign sh  = {rem_q, quo_q[DVD_W-1]};
	assign dif = sh - {1'b0, dvs_q};
	assign ge  = (sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? dif[DVS_W-1:0] : sh[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hw/rtl/sjs_back.sv
module sjs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sjs_pkg::qhead_t           head,
	output logic                      pop,
	input  logic [sjs_pkg::CNT_W-1:0] w_eff,
	sjs_result_if.source              results
);
	import sjs_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_P1_RD   = 4'd1;
	localparam logic [3:0] ST_P1_ACC  = 4'd2;
	localparam logic [3:0] ST_D1_GO   = 4'd3;
	localparam logic [3:0] ST_D1_WAIT = 4'd4;
	localparam logic [3:0] ST_P2_RD   = 4'd5;
	localparam logic [3:0] ST_P2_MUL  = 4'd6;
	localparam logic [3:0] ST_P2_ACC  = 4'd7;
	localparam logic [3:0] ST_D2_GO   = 4'd8;
	localparam logic [3:0] ST_D2_WAIT = 4'd9;
	localparam logic [3:0] ST_OUT     = 4'd10;

	row_t                   mot_mem [MAX_WINDOW];
	row_t                   win_mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  mot_vld_q;

	logic [3:0]             state_q;
	logic [CNT_W-1:0]       r_q;
	logic [BASE_W-1:0]      b_q;
	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       fill_q;
	logic [IDX_W-1:0]       first_q;
	logic [SUM_W-1:0]       sum_m_q;
	logic [SUM_W-1:0]       sum_w_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [PROD_W-1:0]      prod_s1;
	logic [MAG_W-1:0]       am_s1;
	logic                   same_s1;
	logic signed [NUM_W-1:0] num_q;
	logic [DEN_W-1:0]       den_q;
	logic [SIM_W-1:0]       sim_nx_q;
	logic                   zd_nx_q;

	row_t                   win_rd_q;
	row_t                   mot_rd_q;
	logic                   mot_vld_rd_q;
	row_t                   mot_eff;

	logic                   res_vld_q;
	logic [SIM_W-1:0]       res_sim_q;
	logic [SUM_W-1:0]       res_sum_q;
	logic                   res_zd_q;

	logic                   rd_en;
	logic [IDX_W-1:0]       rd_row;
	logic [IDX_W-1:0]       rd_win;
	logic                   win_we;
	logic                   mot_we;
	logic [SUM_W-1:0]       sum_m_nx;
	logic [SUM_W-1:0]       sum_w_nx;
	logic [CNT_W-1:0]       fill_base;
	logic [CNT_W-1:0]       fill_nx;
	logic                   last_row;
	logic [AX_W-1:0]        ax;
	logic [AX_W-1:0]        ay;
	logic [AX_W-1:0]        lo;
	logic [AX_W-1:0]        hi;
	logic [NUM_W-1:0]       an;
	logic                   div_start;
	logic [DVD_W-1:0]       div_dvd;
	logic [DVS_W-1:0]       div_dvs;
	logic                   div_done;
	logic [DVD_W-1:0]       div_quo;
	logic                   out_load;
	logic [VALUE_BITS-1:0]  cur_v;
	logic [VALUE_BITS-1:0]  cur_m;

	assign mot_eff  = mot_vld_rd_q ? mot_rd_q : '0;
	assign rd_en    = (state_q == ST_P1_RD) || (state_q == ST_P2_RD);
	assign rd_row   = r_q[IDX_W-1:0];
	assign rd_win   = first_q + r_q[IDX_W-1:0];
	assign last_row = ((r_q + 1'b1) == w_eff);
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign mot_we   = pop && (head.item.op == OP_MOTIF);
	assign win_we   = pop && (head.item.op == OP_PUSH);
	assign out_load = (state_q == ST_OUT) && (!res_vld_q || results.ready);

	assign fill_base = head.item.start_req ? '0 : fill_q;
	assign fill_nx   = (fill_base == CNT_W'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;

	always_comb begin
		sum_m_nx = sum_m_q;
		sum_w_nx = sum_w_q;
		for (int b = 0; b < BASES; b++) begin
			sum_m_nx = sum_m_nx + SUM_W'(mag(mot_eff[b]));
			sum_w_nx = sum_w_nx + SUM_W'(mag(win_rd_q[b]));
		end
	end

	assign cur_v = win_rd_q[b_q];
	assign cur_m = mot_eff[b_q];

	// Scaled score magnitude, rounded half up.
	assign ax = AX_W'((prod_s1 + PROD_W'(16'h8000)) >> 16);
	assign ay = AX_W'(am_s1);
	assign lo = (ax < ay) ? ax : ay;
	assign hi = (ax < ay) ? ay : ax;
	assign an = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVD_W'(sum_m_q) << 16;
		div_dvs   = DVS_W'(sum_w_q);
		if (state_q == ST_D1_GO) begin
			div_start = 1'b1;
		end else if (state_q == ST_D2_GO) begin
			div_start = (den_q != '0);
			div_dvd   = (DVD_W'(an) << 15) + DVD_W'(den_q);
			div_dvs   = DVS_W'(den_q) << 1;
		end
	end

	sjs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (mot_we) begin
			mot_mem[head.item.row_index] <= head.item.vals;
		end
		if (win_we) begin
			win_mem[head_q] <= head.item.vals;
		end
		if (rd_en) begin
			win_rd_q <= win_mem[rd_win];
			mot_rd_q <= mot_mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mot_vld_q    <= '0;
			mot_vld_rd_q <= 1'b0;
			r_q          <= '0;
			b_q          <= '0;
			head_q       <= '0;
			fill_q       <= '0;
			first_q      <= '0;
			sum_m_q      <= '0;
			sum_w_q      <= '0;
			scale_q      <= '0;
			prod_s1      <= '0;
			am_s1        <= '0;
			same_s1      <= 1'b0;
			num_q        <= '0;
			den_q        <= '0;
			sim_nx_q     <= '0;
			zd_nx_q      <= 1'b0;
			res_vld_q    <= 1'b0;
			res_sim_q    <= '0;
			res_sum_q    <= '0;
			res_zd_q     <= 1'b0;
		end else begin
			if (rd_en) begin
				mot_vld_rd_q <= mot_vld_q[rd_row];
			end
			if (out_load) begin
				res_vld_q <= 1'b1;
				res_sim_q <= sim_nx_q;
				res_sum_q <= sum_w_q;
				res_zd_q  <= zd_nx_q;
			end else if (results.ready) begin
				res_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (mot_we) begin
						mot_vld_q[head.item.row_index] <= 1'b1;
					end
					if (win_we) begin
						head_q <= head_q + 1'b1;
						fill_q <= fill_nx;
						if (fill_nx >= w_eff) begin
							first_q <= head_q + 1'b1 - w_eff[IDX_W-1:0];
							r_q     <= '0;
							sum_m_q <= '0;
							sum_w_q <= '0;
							state_q <= ST_P1_RD;
						end
					end
				end
				ST_P1_RD: begin
					state_q <= ST_P1_ACC;
				end
				ST_P1_ACC: begin
					sum_m_q <= sum_m_nx;
					sum_w_q <= sum_w_nx;
					if (last_row) begin
						r_q   <= '0;
						num_q <= '0;
						den_q <= '0;
						if (sum_w_nx == '0) begin
							scale_q <= '1;
							state_q <= ST_P2_RD;
						end else begin
							state_q <= ST_D1_GO;
						end
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= ST_P1_RD;
					end
				end
				ST_D1_GO: begin
					state_q <= ST_D1_WAIT;
				end
				ST_D1_WAIT: begin
					if (div_done) begin
						scale_q <= (|div_quo[DVD_W-1:SCALE_W]) ? '1 : div_quo[SCALE_W-1:0];
						state_q <= ST_P2_RD;
					end
				end
				ST_P2_RD: begin
					b_q     <= '0;
					state_q <= ST_P2_MUL;
				end
				ST_P2_MUL: begin
					prod_s1 <= PROD_W'(mag(cur_v)) * PROD_W'(scale_q);
					am_s1   <= mag(cur_m);
					same_s1 <= (cur_v[VALUE_BITS-1] == cur_m[VALUE_BITS-1]);
					state_q <= ST_P2_ACC;
				end
				ST_P2_ACC: begin
					num_q <= same_s1 ? num_q + $signed(NUM_W'(lo)) : num_q - $signed(NUM_W'(lo));
					den_q <= den_q + DEN_W'(hi);
					b_q   <= b_q + 1'b1;
					if (b_q == BASE_W'(BASES - 1)) begin
						if (last_row) begin
							state_q <= ST_D2_GO;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= ST_P2_RD;
						end
					end else begin
						state_q <= ST_P2_MUL;
					end
				end
				ST_D2_GO: begin
					if (den_q == '0) begin
						sim_nx_q <= '0;
						zd_nx_q  <= 1'b1;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_D2_WAIT;
					end
				end
				ST_D2_WAIT: begin
					if (div_done) begin
						sim_nx_q <= num_q[NUM_W-1] ? (~div_quo[SIM_W-1:0] + 1'b1)
							: div_quo[SIM_W-1:0];
						zd_nx_q  <= 1'b0;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid            = res_vld_q;
	assign results.similarity       = res_sim_q;
	assign results.window_abs_sum   = res_sum_q;
	assign results.zero_denominator = res_zd_q;

endmodule

### tb/sv/jaccard_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the configuration port, keeps its own copy of the
// motif matrix and score window, and compares every result item with the
// oldest predicted one.
module jaccard_checker (
	input  logic  clk,
	input  logic  arst_n,
	sjs_item_if   items,
	sjs_result_if results,
	input  logic  cfg_wr_en,
	input  logic [sjs_pkg::CNT_W-1:0] cfg_wr_data,
	output int    failures,
	output int    pending,
	output int    results_seen,
	output int    zero_den_seen
);
	import sjs_pkg::*;

	typedef struct {
		logic signed [SIM_W-1:0] sim;
		logic [SUM_W-1:0]        abs_sum;
		logic                    zero_den;
	} jaccard_t;

	logic signed [VALUE_BITS-1:0] motif_mem [MAX_WINDOW][BASES];
	logic signed [VALUE_BITS-1:0] score_mem [MAX_WINDOW][BASES];
	int unsigned head_ptr;
	int unsigned fill_rows;
	logic [CNT_W-1:0] win_len;
	jaccard_t jaccard_queue[$];

	function automatic longint unsigned magnitude(logic signed [VALUE_BITS-1:0] v);
		longint signed w;
		w = v;
		return (w < 0) ? longint'(-w) : longint'(w);
	endfunction

	// Applies one accepted item to the model state and queues a result when
	// the window is full.
	task automatic apply_item(logic op_bit, logic [IDX_W-1:0] idx, logic start,
		logic signed [VALUE_BITS-1:0] vals [BASES]);
		int unsigned w, first, s;
		longint unsigned sum_m, sum_w, scale, den, ax, ay, lo, hi, an, q;
		longint signed num;
		jaccard_t res;
		sum_m = 0;
		sum_w = 0;
		den = 0;
		num = 0;
		if (op_bit == OP_MOTIF) begin
			for (int b = 0; b < BASES; b++) motif_mem[idx][b] = vals[b];
			return;
		end
		if (start) fill_rows = 0;
		for (int b = 0; b < BASES; b++) score_mem[head_ptr][b] = vals[b];
		head_ptr = (head_ptr + 1) % MAX_WINDOW;
		if (fill_rows < MAX_WINDOW) fill_rows++;
		w = win_len;
		if (w == 0) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		if (fill_rows < w) return;
		first = (head_ptr + MAX_WINDOW - w) % MAX_WINDOW;
		for (int r = 0; r < w; r++) begin
			s = (first + r) % MAX_WINDOW;
			for (int b = 0; b < BASES; b++) begin
				sum_m += magnitude(motif_mem[r][b]);
				sum_w += magnitude(score_mem[s][b]);
			end
		end
		if (sum_w == 0) begin
			scale = 64'hFFFF_FFFF;
		end else begin
			scale = (sum_m << 16) / sum_w;
			if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
		end
		for (int r = 0; r < w; r++) begin
			s = (first + r) % MAX_WINDOW;
			for (int b = 0; b < BASES; b++) begin
				ax = (magnitude(score_mem[s][b]) * scale + 64'h8000) >> 16;
				ay = magnitude(motif_mem[r][b]);
				lo = (ax < ay) ? ax : ay;
				hi = (ax < ay) ? ay : ax;
				if ((score_mem[s][b] < 0) == (motif_mem[r][b] < 0)) num += longint'(lo);
				else num -= longint'(lo);
				den += hi;
			end
		end
		if (den == 0) begin
			res.sim = '0;
			res.zero_den = 1'b1;
		end else begin
			an = (num < 0) ? longint'(-num) : longint'(num);
			q = (an * 32768 + den) / (2 * den);
			res.sim = (num < 0) ? SIM_W'(-longint'(q)) : SIM_W'(q);
			res.zero_den = 1'b0;
		end
		res.abs_sum = SUM_W'(sum_w);
		jaccard_queue.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [VALUE_BITS-1:0] vals [BASES];
		jaccard_t exp_res;
		if (!arst_n) begin
			for (int r = 0; r < MAX_WINDOW; r++)
				for (int b = 0; b < BASES; b++) motif_mem[r][b] = '0;
			head_ptr = 0;
			fill_rows = 0;
			win_len = WIN_RESET;
			failures = 0;
			results_seen = 0;
			zero_den_seen = 0;
			jaccard_queue.delete();
		end else begin
			if (results.valid && results.ready) begin
				results_seen++;
				if (jaccard_queue.size() == 0) begin
					$error("result item arrived with nothing predicted");
					failures++;
				end else begin
					exp_res = jaccard_queue.pop_front();
					if (exp_res.zero_den) zero_den_seen++;
					if (results.similarity !== exp_res.sim) begin
						$error("similarity: expected %0d, got %0d", exp_res.sim,
							results.similarity);
						failures++;
					end
					if (results.window_abs_sum !== exp_res.abs_sum) begin
						$error("window_abs_sum: expected %0d, got %0d", exp_res.abs_sum,
							results.window_abs_sum);
						failures++;
					end
					if (results.zero_denominator !== exp_res.zero_den) begin
						$error("zero_denominator: expected %0b, got %0b", exp_res.zero_den,
							results.zero_denominator);
						failures++;
					end
				end
			end
			if (items.valid && items.ready) begin
				vals[0] = items.value_a;
				vals[1] = items.value_c;
				vals[2] = items.value_g;
				vals[3] = items.value_t;
				apply_item(items.op, items.row_index, items.start_req, vals);
			end
			if (cfg_wr_en) win_len = cfg_wr_data;
		end
		pending = jaccard_queue.size();
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

// Top of the bench for the sliding Jaccard scan. It generates clock and reset,
// writes the window length between phases, drives motif loads and score pushes,
// and randomly stalls the result port. Result checking lives in jaccard_checker.
module testbench;
	import sjs_pkg::*;

	localparam int ITEMS_PER_PHASE = 200;
	localparam int DRAIN_CYCLES    = 600;
	localparam int CYCLE_LIMIT     = 4000000;
	localparam int LONG_HOLD       = 4000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	int failures, pending, results_seen, zero_den_seen;
	int tx_idle_pct, rx_idle_pct;
	int items_sent;
	int cycle_count;
	bit long_hold_armed;

	sjs_item_if   item_ch ();
	sjs_result_if result_ch ();

	sliding_continuous_jaccard_scan_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (item_ch),
		.results     (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	jaccard_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.items         (item_ch),
		.results       (result_ch),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.failures      (failures),
		.pending       (pending),
		.results_seen  (results_seen),
		.zero_den_seen (zero_den_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The run is cut off if the block hangs somewhere.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("sliding_continuous_jaccard_scan_unit verification failed");
			$finish;
		end
	end

	// The receiver stalls at random. When a long hold is armed it keeps ready
	// low for a long stretch so that the input queue fills and the block stops
	// taking items while the sender keeps offering.
	always @(negedge clk) begin
		int hold_left;
		if (long_hold_armed && hold_left == 0) begin
			hold_left = LONG_HOLD;
			long_hold_armed = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Values lean toward the extremes, zero and small magnitudes, which are
	// where the scale saturates and the sign rules matter most.
	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return VALUE_BITS'(int'($urandom_range(64)) - 32);
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	// Offers one item and holds it until the block takes it. The sender may
	// idle first, with valid low.
	task automatic send_item(logic op_bit, logic [IDX_W-1:0] idx, logic start,
		logic [VALUE_BITS-1:0] a, logic [VALUE_BITS-1:0] c,
		logic [VALUE_BITS-1:0] g, logic [VALUE_BITS-1:0] t);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.op        <= op_bit;
		item_ch.row_index <= idx;
		item_ch.start_req <= start;
		item_ch.value_a   <= a;
		item_ch.value_c   <= c;
		item_ch.value_g   <= g;
		item_ch.value_t   <= t;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Writes the window length once every predicted result is out and the
	// back end has had time to retire anything still in its queue.
	task automatic set_window(logic [CNT_W-1:0] rows);
		item_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rows;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		@(negedge clk);
	endtask

	// Random traffic: mostly score pushes with the odd new sequence, some motif
	// reloads, and some all-zero rows so that empty windows come up.
	task automatic random_traffic(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0)
				send_item(OP_MOTIF, IDX_W'($urandom), 1'b0, pick_value(), pick_value(),
					pick_value(), pick_value());
			else if ($urandom_range(19) == 0)
				send_item(OP_PUSH, IDX_W'($urandom), ($urandom_range(24) == 0), '0, '0,
					'0, '0);
			else
				send_item(OP_PUSH, IDX_W'($urandom), ($urandom_range(24) == 0),
					pick_value(), pick_value(), pick_value(), pick_value());
		end
	endtask

	initial begin
		int win_plan [6];
		win_plan = '{1, 32, 0, 63, 7, -1};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_MOTIF;
		item_ch.row_index = '0;
		item_ch.start_req = 1'b0;
		item_ch.value_a = '0;
		item_ch.value_c = '0;
		item_ch.value_g = '0;
		item_ch.value_t = '0;
		result_ch.ready = 1'b0;
		tx_idle_pct = 30;
		rx_idle_pct = 77;
		items_sent = 0;
		cycle_count = 0;
		long_hold_armed = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with a two-row window.
		set_window(6'd2);
		// An all-zero motif against all-zero scores: the union sum is zero.
		send_item(OP_MOTIF, 5'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_MOTIF, 5'd1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_PUSH, 5'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_PUSH, 5'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// Extreme motif values, then extreme scores with mixed signs.
		send_item(OP_MOTIF, 5'd0, 1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
		send_item(OP_MOTIF, 5'd1, 1'b1, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
		send_item(OP_PUSH, 5'd0, 1'b0, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001);
		// A new sequence restarts the fill, so this push gives nothing.
		send_item(OP_PUSH, 5'd31, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
		// Tiny scores against a large motif sum, with the extreme row before them still in the window.
		send_item(OP_PUSH, 5'd0, 1'b0, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
		// Zero window sum with a nonzero motif.
		send_item(OP_PUSH, 5'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_PUSH, 5'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_MOTIF, 5'd31, 1'b0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_item(OP_PUSH, 5'd5, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(OP_PUSH, 5'd5, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);

		// Random phases walk the window lengths, extremes and out-of-range
		// values included, with the idle pattern changing every two phases.
		for (int p = 0; p < 6; p++) begin
			set_window((win_plan[p] < 0) ? CNT_W'($urandom_range(1, 32)) :
				CNT_W'(win_plan[p]));
			case (p / 2)
				0: begin tx_idle_pct = 30; rx_idle_pct = 77; end
				1: begin tx_idle_pct = 77; rx_idle_pct = 30; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			if (p == 4) long_hold_armed = 1;
			random_traffic(ITEMS_PER_PHASE);
		end

		item_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d items over window lengths 0, 1, 2, 7, 32, 63 and a random one;",
			items_sent);
		$display("checked %0d results, %0d of them with a zero union sum.", results_seen,
			zero_den_seen);
		if (failures == 0 && pending == 0) begin
			$display("sliding_continuous_jaccard_scan_unit verification clean");
		end else begin
			$display("sliding_continuous_jaccard_scan_unit verification failed");
		end
		$finish;
	end

endmodule
